// ===== sv/lgl_pkg.sv =====
// ----------------------------------------------------------------------------
// lgl_pkg
// Shared types and constants for the piecewise-linear luma gamma block.
// ----------------------------------------------------------------------------
package lgl_pkg;

    localparam int MAX_POINTS_DEF          = 64;
    localparam int CURVE_FRACTION_BITS_DEF = 16;

    localparam int PIX_W     = 8;
    localparam int OUT_W     = 8;
    localparam int NP_W      = 7;
    localparam int BITS_W    = 4;
    localparam int EIDX_W    = 6;
    localparam int FRAC_N_W  = PIX_W + NP_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = NP_W;

    localparam logic [NP_W-1:0]   NUM_POINTS_RST  = NP_W'(33);
    localparam logic [BITS_W-1:0] INPUT_BITS_RST  = BITS_W'(8);
    localparam logic [BITS_W-1:0] OUTPUT_BITS_RST = BITS_W'(8);

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_POINTS  = 2'd0,
        REG_INPUT_BITS  = 2'd1,
        REG_OUTPUT_BITS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [NP_W-1:0]   num_points;
        logic [BITS_W-1:0] input_bits;
        logic [BITS_W-1:0] output_bits;
    } cfg_t;

    typedef struct packed {
        logic [BITS_W-1:0]   ib;
        logic [BITS_W-1:0]   ob;
        logic [FRAC_N_W-1:0] frac;
    } seg_info_t;

endpackage

// ===== sv/lgl_index.sv =====
// ----------------------------------------------------------------------------
// lgl_index
// Segment index and fraction from the pixel; first pipeline stage.
// ----------------------------------------------------------------------------
module lgl_index
    import lgl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int IDX_W      = $clog2(MAX_POINTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic              command,
    input  logic [PIX_W-1:0]  pixel_in,
    input  logic              ready_next,
    output logic              ready,
    output logic [IDX_W-1:0]  addr0,
    output logic [IDX_W-1:0]  addr1,
    output logic              valid,
    output seg_info_t         info
);

    logic [NP_W-1:0]     p;
    logic [NP_W-1:0]     pm1;
    logic [NP_W-1:0]     lim;
    logic [FRAC_N_W-1:0] n;
    logic [FRAC_N_W-1:0] idx_raw;
    logic [FRAC_N_W-1:0] idx;
    logic                valid_reg;
    logic                valid_next;
    seg_info_t           info_reg;
    seg_info_t           info_next;

    always_comb
    begin
        if (cfg.num_points < NP_W'(2))
        begin
            p = NP_W'(2);
        end
        else if (32'(cfg.num_points) > MAX_POINTS)
        begin
            p = NP_W'(MAX_POINTS);
        end
        else
        begin
            p = cfg.num_points;
        end
        pm1     = p - NP_W'(1);
        lim     = p - NP_W'(2);
        n       = FRAC_N_W'(pixel_in) * FRAC_N_W'(pm1);
        idx_raw = n >> cfg.input_bits;
        // clamp to the top segment, past it the curve extrapolates
        if (idx_raw > FRAC_N_W'(lim))
        begin
            idx = FRAC_N_W'(lim);
        end
        else
        begin
            idx = idx_raw;
        end
        info_next.ib   = cfg.input_bits;
        info_next.ob   = cfg.output_bits;
        info_next.frac = n - (idx << cfg.input_bits);
        valid_next     = in_valid && (command == CMD_PIXEL);
    end

    assign addr0 = idx[IDX_W-1:0];
    assign addr1 = idx[IDX_W-1:0] + IDX_W'(1);
    assign ready = !valid_reg || ready_next;
    assign valid = valid_reg;
    assign info  = info_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            info_reg <= info_next;
        end
    end

endmodule

// ===== sv/lgl_curve_mem.sv =====
// ----------------------------------------------------------------------------
// lgl_curve_mem
// Curve point storage: two mirrored banks, one read port each.
// ----------------------------------------------------------------------------
module lgl_curve_mem
    import lgl_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int EW         = CURVE_FRACTION_BITS_DEF + 1,
    parameter int IDX_W      = $clog2(MAX_POINTS)
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [EIDX_W-1:0] wr_index,
    input  logic [EW-1:0]     wr_data,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr0,
    input  logic [IDX_W-1:0]  rd_addr1,
    output logic [EW-1:0]     rd_data0,
    output logic [EW-1:0]     rd_data1
);

    localparam int AW = (IDX_W > EIDX_W) ? IDX_W : EIDX_W;

    logic [EW-1:0]    bank0 [MAX_POINTS];
    logic [EW-1:0]    bank1 [MAX_POINTS];
    logic [AW-1:0]    wide_index;
    logic             in_table;
    logic [IDX_W-1:0] waddr;
    logic [EW-1:0]    rd_data0_reg;
    logic [EW-1:0]    rd_data1_reg;

    // writes past the table are dropped
    assign wide_index = AW'(wr_index);
    assign in_table   = ({1'b0, wide_index} < (AW+1)'(MAX_POINTS));
    assign waddr      = wide_index[IDX_W-1:0];
    assign rd_data0   = rd_data0_reg;
    assign rd_data1   = rd_data1_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en && in_table)
        begin
            bank0[waddr] <= wr_data;
            bank1[waddr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data0_reg <= bank0[rd_addr0];
            rd_data1_reg <= bank1[rd_addr1];
        end
    end

endmodule

// ===== sv/lgl_interp.sv =====
// ----------------------------------------------------------------------------
// lgl_interp
// Interpolation, output scaling and saturation; three pipeline stages.
// ----------------------------------------------------------------------------
module lgl_interp
    import lgl_pkg::*;
#(
    parameter int CURVE_FRACTION_BITS = CURVE_FRACTION_BITS_DEF,
    parameter int EW                  = CURVE_FRACTION_BITS + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  seg_info_t        info,
    input  logic [EW-1:0]    c0,
    input  logic [EW-1:0]    c1,
    output logic             ready,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [OUT_W-1:0] pixel_out
);

    localparam int SW  = EW + FRAC_N_W + 2;
    localparam int PW  = SW - 1 + (1 << BITS_W) - 1;
    localparam int SHW = $clog2((1 << BITS_W) + CURVE_FRACTION_BITS);

    logic signed [EW:0]       diff;
    logic signed [FRAC_N_W:0] frac_s;
    logic signed [SW-1:0]     c0_sh;
    logic signed [SW-1:0]     fd;
    logic signed [SW-1:0]     sum_next;
    logic signed [SW-1:0]     sum_reg;
    logic [BITS_W-1:0]        ib2_reg;
    logic [BITS_W-1:0]        ob2_reg;
    logic                     valid2_reg;
    logic                     ready2;

    logic [PW-1:0]            sp;
    logic [PW-1:0]            prod_next;
    logic [PW-1:0]            prod_reg;
    logic [BITS_W-1:0]        ib3_reg;
    logic                     valid3_reg;
    logic                     ready3;

    logic [SHW-1:0]           sh;
    logic [PW-1:0]            q;
    logic [OUT_W-1:0]         pix_next;
    logic [OUT_W-1:0]         pixel_out_reg;
    logic                     out_valid_reg;
    logic                     ready_o;

    assign ready_o   = !out_valid_reg || out_ready;
    assign ready3    = !valid3_reg || ready_o;
    assign ready2    = !valid2_reg || ready3;
    assign ready     = ready2;
    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_out_reg;

    // sum = c0 * 2^ib + frac * (c1 - c0)
    always_comb
    begin
        diff     = $signed({1'b0, c1}) - $signed({1'b0, c0});
        frac_s   = $signed({1'b0, info.frac});
        c0_sh    = $signed(SW'(c0)) <<< info.ib;
        fd       = frac_s * diff;
        sum_next = c0_sh + fd;
    end

    // scale by 2^ob - 1, negative or zero gives zero
    always_comb
    begin
        sp = PW'(sum_reg[SW-2:0]);
        if (sum_reg[SW-1] || (sum_reg == '0))
        begin
            prod_next = '0;
        end
        else
        begin
            prod_next = (sp << ob2_reg) - sp;
        end
    end

    always_comb
    begin
        sh = SHW'(ib3_reg) + SHW'(CURVE_FRACTION_BITS);
        q  = prod_reg >> sh;
        if (|q[PW-1:OUT_W])
        begin
            pix_next = '1;
        end
        else
        begin
            pix_next = q[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                valid2_reg <= in_valid;
            end
            if (ready3)
            begin
                valid3_reg <= valid2_reg;
            end
            if (ready_o)
            begin
                out_valid_reg <= valid3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2)
        begin
            sum_reg <= sum_next;
            ib2_reg <= info.ib;
            ob2_reg <= info.ob;
        end
        if (ready3)
        begin
            prod_reg <= prod_next;
            ib3_reg  <= ib2_reg;
        end
        if (ready_o)
        begin
            pixel_out_reg <= pix_next;
        end
    end

endmodule

// ===== sv/luma_gamma_interpolated_lut_top.sv =====
// ----------------------------------------------------------------------------
// luma_gamma_interpolated_lut_top
// Luma gamma correction through a piecewise-linear curve table.
// ----------------------------------------------------------------------------
//   channel  handshake              payload
//   in       in_valid / in_ready    command, pixel_in, entry_index, entry_value
//   out      out_valid / out_ready  pixel_out
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//   one word per cycle on in while out does not stall; a pixel word gives its result
//   through the table read, interpolate multiply, scale, shift and saturate stages
//   a curve write lands in the table at its accept edge and gives no word
//   reset loads the config defaults and clears pipeline valids, not the table
//   stalls on out ripple back stage by stage; empty stages keep accepting
// ----------------------------------------------------------------------------
module luma_gamma_interpolated_lut_top
    import lgl_pkg::*;
#(
    parameter int MAX_POINTS          = MAX_POINTS_DEF,
    parameter int CURVE_FRACTION_BITS = CURVE_FRACTION_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         command,
    input  logic [PIX_W-1:0]             pixel_in,
    input  logic [EIDX_W-1:0]            entry_index,
    input  logic [CURVE_FRACTION_BITS:0] entry_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [OUT_W-1:0]             pixel_out,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DAT_W-1:0]         cfg_data
);

    localparam int EW    = CURVE_FRACTION_BITS + 1;
    localparam int IDX_W = $clog2(MAX_POINTS);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    logic             in_fire;
    logic             ready1;
    logic             ready2;
    logic             valid1;
    seg_info_t        info1;
    logic [IDX_W-1:0] addr0;
    logic [IDX_W-1:0] addr1;
    logic [EW-1:0]    c0;
    logic [EW-1:0]    c1;

    assign cfg_ready = 1'b1;
    assign in_ready  = ready1;
    assign in_fire   = in_valid && ready1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NUM_POINTS:  cfg_next.num_points  = cfg_data[NP_W-1:0];
                REG_INPUT_BITS:  cfg_next.input_bits  = cfg_data[BITS_W-1:0];
                REG_OUTPUT_BITS: cfg_next.output_bits = cfg_data[BITS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_points  <= NUM_POINTS_RST;
            cfg_reg.input_bits  <= INPUT_BITS_RST;
            cfg_reg.output_bits <= OUTPUT_BITS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lgl_index #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_index (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .command    (command),
        .pixel_in   (pixel_in),
        .ready_next (ready2),
        .ready      (ready1),
        .addr0      (addr0),
        .addr1      (addr1),
        .valid      (valid1),
        .info       (info1)
    );

    lgl_curve_mem #(
        .MAX_POINTS (MAX_POINTS),
        .EW         (EW),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (in_fire && (command == CMD_WRITE)),
        .wr_index (entry_index),
        .wr_data  (entry_value),
        .rd_en    (ready1),
        .rd_addr0 (addr0),
        .rd_addr1 (addr1),
        .rd_data0 (c0),
        .rd_data1 (c1)
    );

    lgl_interp #(
        .CURVE_FRACTION_BITS (CURVE_FRACTION_BITS),
        .EW                  (EW)
    ) u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid1),
        .info      (info1),
        .c0        (c0),
        .c1        (c1),
        .ready     (ready2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pixel_out (pixel_out)
    );

endmodule
